FILE: rtl/touch_window_detector_assert.svh
// assertion macros shared by the touch window detector rtl
`ifndef TOUCH_WINDOW_DETECTOR_ASSERT_SVH
`define TOUCH_WINDOW_DETECTOR_ASSERT_SVH
`ifndef SYNTH
// checked on every rising edge of clk, off while arst_n is low
`define TWD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every rising edge of clk, reset included
`define TWD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWD_ASSERT(lbl, prop, msg)
`define TWD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/twt_pkg.sv
// constants and types of the touch window detector
package twt_pkg;

	// window layout
	localparam int BASELINE_MAX = 32;
	localparam int GAP_MAX      = 16;
	localparam int RECENT_MAX   = 16;
	localparam int WIN_DEPTH    = BASELINE_MAX + GAP_MAX + RECENT_MAX;
	localparam int AW           = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

	// field widths
	localparam int SAMPLE_W  = 16;
	localparam int THR_W     = 16;
	localparam int BLEN_CFG_W = 6;
	localparam int GAP_CFG_W  = 5;
	localparam int RLEN_CFG_W = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int POL_W      = 2;

	// lengths after clamping
	localparam int LEN_MAX = (BASELINE_MAX > RECENT_MAX) ? BASELINE_MAX : RECENT_MAX;
	localparam int LEN_W   = $clog2(LEN_MAX + 1);
	localparam int BL_W    = $clog2(BASELINE_MAX + 1);
	localparam int RL_W    = $clog2(RECENT_MAX + 1);
	localparam int GL_W    = (GAP_MAX > 0) ? $clog2(GAP_MAX + 1) : 1;
	localparam int CNT_W   = $clog2(BASELINE_MAX + RECENT_MAX + 1);

	// accumulator and divider
	localparam int SUM_W  = SAMPLE_W + LEN_W;
	localparam int DCNT_W = $clog2(SUM_W);

	// stream payloads
	localparam int IN_DATA_W  = SAMPLE_W;
	localparam int OUT_RAW_W  = 1 + POL_W + 2 * SAMPLE_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD    = 4'd0,
		CFG_BASELINE_LEN = 4'd1,
		CFG_GAP_LEN      = 4'd2,
		CFG_RECENT_LEN   = 4'd3
	} cfg_idx_t;

	// polarity codes
	typedef enum logic [POL_W-1:0] {
		POL_UNKNOWN = 2'd0,
		POL_RISE    = 2'd1,
		POL_FALL    = 2'd2
	} pol_t;

endpackage

FILE: rtl/twt_ram.sv
// generic single write, single read ram with registered read data
module twt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/touch_window_detector.sv
// top level of the touch window detector
//
// takes one touch sample per input transfer and shifts it into a 64 entry
// window held in a ring ram. the newest recent_len samples are averaged as the
// touch level, then gap_len samples are skipped, then the next baseline_len
// samples are averaged as the baseline; both averages are floor averages. a
// touch level above baseline + threshold is a rise, one below baseline -
// threshold is a fall. the first rise or fall fixes the polarity and sets
// touched; afterwards a crossing in the fixed direction sets touched and the
// opposite crossing clears it. with tuser set the sample is only shifted in and
// the decision is left as it was, but both averages are still reported. every
// input transfer gives exactly one output transfer. window entries never
// written since reset read as zero through a fill count, so there is no
// clearing pass after reset. each item makes one ram read per window sample on
// the single read port, then two 22 step bit-serial divisions for the averages.
// a new input transfer is taken as soon as the result sits in the output
// register, even if it has not been taken yet. registers are to be written
// through the cfg port only while no item is in flight; the block itself does
// not enforce this.
`include "touch_window_detector_assert.svh"

module touch_window_detector (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [twt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [twt_pkg::CFG_DATA_W-1:0]   cfg_data,
	// sample stream in
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [twt_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // sample
	input  logic                             s_axis_tuser,  // prime_only
	// decision stream out
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// touched, polarity, baseline_avg, recent_avg, zero padding
	output logic [twt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	import twt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DRAIN,
		S_DIV,
		S_OUT
	} state_t;

	// configuration registers
	logic [THR_W-1:0]      thr_q;
	logic [BLEN_CFG_W-1:0] blen_q;
	logic [GAP_CFG_W-1:0]  gap_q;
	logic [RLEN_CFG_W-1:0] rlen_q;

	// clamped lengths
	logic [BL_W-1:0]  b_c;
	logic [GL_W-1:0]  g_c;
	logic [RL_W-1:0]  r_c;
	logic [CNT_W-1:0] total_c;

	// control
	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [AW:0]       fill_q;
	logic              prime_q;
	logic [CNT_W-1:0]  k_q;

	// read pipeline
	logic              rd_vld_s1;
	logic              rd_rec_s1;
	logic              rd_live_s1;
	logic [AW:0]       age_w;
	logic [AW:0]       addr_sum;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     head_nxt;
	logic [SAMPLE_W-1:0] rdata;
	logic              last_rd;

	// accumulators and divider
	logic [SUM_W-1:0]  sum_rec_q;
	logic [SUM_W-1:0]  sum_base_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [LEN_W-1:0]  rem_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              div_base_q;
	logic [LEN_W-1:0]  divisor;
	logic [LEN_W:0]    shifted;
	logic              qbit;
	logic [LEN_W-1:0]  rem_nxt;
	logic [SUM_W-1:0]  dvd_nxt;

	// averages and decision
	logic [SAMPLE_W-1:0] rec_avg_q;
	logic [SAMPLE_W-1:0] base_avg_q;
	pol_t                pol_q;
	logic                touched_q;
	logic                rise;
	logic                fall;
	pol_t                pol_nxt;
	logic                touched_nxt;

	// output register
	logic                m_valid_q;
	logic [SAMPLE_W-1:0] out_rec_q;
	logic [SAMPLE_W-1:0] out_base_q;
	pol_t                out_pol_q;
	logic                out_touched_q;

	logic in_xfer;
	logic out_free;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - OUT_RAW_W){1'b0}}, out_rec_q, out_base_q,
		out_pol_q, out_touched_q};

	// register file, to be written only between items; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			blen_q <= BLEN_CFG_W'(32);
			gap_q  <= '0;
			rlen_q <= RLEN_CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_THRESHOLD:    thr_q  <= cfg_data[THR_W-1:0];
				CFG_BASELINE_LEN: blen_q <= cfg_data[BLEN_CFG_W-1:0];
				CFG_GAP_LEN:      gap_q  <= cfg_data[GAP_CFG_W-1:0];
				CFG_RECENT_LEN:   rlen_q <= cfg_data[RLEN_CFG_W-1:0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// zero baseline and recent lengths act as one, all lengths saturate at their maximum
	always_comb begin
		if (blen_q == '0) begin
			b_c = BL_W'(1);
		end else if (int'(blen_q) > BASELINE_MAX) begin
			b_c = BL_W'(BASELINE_MAX);
		end else begin
			b_c = BL_W'(blen_q);
		end
		if (int'(gap_q) > GAP_MAX) begin
			g_c = GL_W'(GAP_MAX);
		end else begin
			g_c = GL_W'(gap_q);
		end
		if (rlen_q == '0) begin
			r_c = RL_W'(1);
		end else if (int'(rlen_q) > RECENT_MAX) begin
			r_c = RL_W'(RECENT_MAX);
		end else begin
			r_c = RL_W'(rlen_q);
		end
		total_c = CNT_W'(r_c) + CNT_W'(b_c);
	end

	// ring position of the k-th sample read: touch part first, then baseline
	always_comb begin
		if (k_q < CNT_W'(r_c)) begin
			age_w = (AW+1)'(k_q);
		end else begin
			age_w = (AW+1)'(k_q) + (AW+1)'(g_c);
		end
		addr_sum = (AW+1)'(head_q) + (AW+1)'(WIN_DEPTH) - age_w;
		if (addr_sum >= (AW+1)'(WIN_DEPTH)) begin
			rd_addr = AW'(addr_sum - (AW+1)'(WIN_DEPTH));
		end else begin
			rd_addr = AW'(addr_sum);
		end
		last_rd = (k_q == total_c - CNT_W'(1));
	end

	assign head_nxt = (head_q == AW'(WIN_DEPTH - 1)) ? '0 : head_q + AW'(1);

	twt_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WIN_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (head_nxt),
		.wdata (s_axis_tdata[SAMPLE_W-1:0]),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// one restoring division step
	always_comb begin
		divisor = div_base_q ? LEN_W'(b_c) : LEN_W'(r_c);
		shifted = {rem_q, dvd_q[SUM_W-1]};
		qbit    = (shifted >= (LEN_W+1)'(divisor));
		rem_nxt = qbit ? LEN_W'(shifted - (LEN_W+1)'(divisor)) : LEN_W'(shifted);
		dvd_nxt = {dvd_q[SUM_W-2:0], qbit};
	end

	// exact compares, one bit of headroom so nothing wraps
	always_comb begin
		rise = {1'b0, rec_avg_q} > ({1'b0, base_avg_q} + {1'b0, thr_q});
		fall = ({1'b0, rec_avg_q} + {1'b0, thr_q}) < {1'b0, base_avg_q};
		pol_nxt     = pol_q;
		touched_nxt = touched_q;
		case (pol_q)
			POL_UNKNOWN: begin
				if (rise) begin
					pol_nxt     = POL_RISE;
					touched_nxt = 1'b1;
				end else if (fall) begin
					pol_nxt     = POL_FALL;
					touched_nxt = 1'b1;
				end
			end
			POL_RISE: begin
				if (rise) begin
					touched_nxt = 1'b1;
				end else if (fall) begin
					touched_nxt = 1'b0;
				end
			end
			default: begin
				if (fall) begin
					touched_nxt = 1'b1;
				end else if (rise) begin
					touched_nxt = 1'b0;
				end
			end
		endcase
	end

	// sequencer with its registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			fill_q        <= '0;
			prime_q       <= 1'b0;
			k_q           <= '0;
			rd_vld_s1     <= 1'b0;
			rd_rec_s1     <= 1'b0;
			rd_live_s1    <= 1'b0;
			sum_rec_q     <= '0;
			sum_base_q    <= '0;
			dvd_q         <= '0;
			rem_q         <= '0;
			div_cnt_q     <= '0;
			div_base_q    <= 1'b0;
			rec_avg_q     <= '0;
			base_avg_q    <= '0;
			pol_q         <= POL_UNKNOWN;
			touched_q     <= 1'b0;
			m_valid_q     <= 1'b0;
			out_rec_q     <= '0;
			out_base_q    <= '0;
			out_pol_q     <= POL_UNKNOWN;
			out_touched_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_READ);

			// output register fills at the finish step, empties on a transfer
			if ((state_q == S_OUT) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			// samples come back in the cycle after their address, from the registered ram read
			if (rd_vld_s1) begin
				if (rd_rec_s1) begin
					sum_rec_q <= sum_rec_q + (rd_live_s1 ? SUM_W'(rdata) : '0);
				end else begin
					sum_base_q <= sum_base_q + (rd_live_s1 ? SUM_W'(rdata) : '0);
				end
			end else if (in_xfer) begin
				sum_rec_q  <= '0;
				sum_base_q <= '0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						head_q     <= head_nxt;
						if (fill_q != (AW+1)'(WIN_DEPTH)) begin
							fill_q <= fill_q + (AW+1)'(1);
						end
						prime_q    <= s_axis_tuser;
						k_q        <= '0;
						state_q    <= S_READ;
					end
				end
				S_READ: begin
					rd_rec_s1  <= (k_q < CNT_W'(r_c));
					rd_live_s1 <= (age_w < fill_q);
					k_q        <= k_q + CNT_W'(1);
					if (last_rd) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// the last read is a baseline sample, the touch sum is complete
					dvd_q      <= sum_rec_q;
					rem_q      <= '0;
					div_cnt_q  <= DCNT_W'(SUM_W - 1);
					div_base_q <= 1'b0;
					state_q    <= S_DIV;
				end
				S_DIV: begin
					if ((div_cnt_q == '0) && !div_base_q) begin
						// touch average done, start on the baseline sum
						rec_avg_q  <= SAMPLE_W'(dvd_nxt);
						dvd_q      <= sum_base_q;
						rem_q      <= '0;
						div_cnt_q  <= DCNT_W'(SUM_W - 1);
						div_base_q <= 1'b1;
					end else begin
						dvd_q     <= dvd_nxt;
						rem_q     <= rem_nxt;
						div_cnt_q <= div_cnt_q - DCNT_W'(1);
						if (div_cnt_q == '0) begin
							base_avg_q <= SAMPLE_W'(dvd_nxt);
							state_q    <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (!prime_q) begin
							pol_q         <= pol_nxt;
							touched_q     <= touched_nxt;
							out_pol_q     <= pol_nxt;
							out_touched_q <= touched_nxt;
						end else begin
							out_pol_q     <= pol_q;
							out_touched_q <= touched_q;
						end
						out_rec_q  <= rec_avg_q;
						out_base_q <= base_avg_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TWD_ASSERT(a_pol_sticky, (pol_q != POL_UNKNOWN) |=> $stable(pol_q), "polarity moved")
	`TWD_ASSERT(a_touch_needs_pol, touched_q |-> (pol_q != POL_UNKNOWN), "touched, no polarity")
	`TWD_ASSERT(a_fill_bound, fill_q <= (AW+1)'(WIN_DEPTH), "fill count beyond depth")
	`TWD_ASSERT(a_out_from_finish, $rose(m_axis_tvalid) |-> $past(state_q == S_OUT), "early result")
	`TWD_ASSERT(a_accept_starts_read, in_xfer |=> (state_q == S_READ), "read did not start")

endmodule
